### hw/rtl/usq_pkg.sv
// Shared types, constants and helpers for the UV-sphere quad vertex generator.
// No dependencies.
package usq_pkg;

  localparam int unsigned RADIUS_W = 14;
  localparam int unsigned SLICE_W  = 9;
  localparam int unsigned LON_W    = 8;
  localparam int unsigned LAT_W    = 7;
  localparam int unsigned PHASE_W  = 16;
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned RCP_W    = 30;

  localparam int unsigned MAX_SLICES = 256;

  localparam logic [RADIUS_W-1:0] RADIUS_MAX   = 14'd8192;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 14'd2458;
  localparam logic [SLICE_W-1:0]  SLICE_RESET  = 9'd50;
  localparam logic [SLICE_W-1:0]  SLICE_MIN    = 9'd6;
  localparam logic [PHASE_W-1:0]  QUARTER_TURN = 16'h4000;
  localparam logic [SLOT_W-1:0]   LAST_SLOT    = 3'd5;

  typedef enum logic {
    REG_RADIUS = 1'b0,
    REG_SLICES = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic               ok;
    logic [PHASE_W-1:0] phi0;
    logic [PHASE_W-1:0] phi1;
    logic [PHASE_W-1:0] th0;
    logic [PHASE_W-1:0] th1;
  } quad_t;

  // bit 0 selects the second longitude, bit 1 the second latitude
  function automatic logic [1:0] corner_of(input logic [SLOT_W-1:0] slot);
    logic [1:0] c;
    case (slot)
      3'd0: c = 2'd1;
      3'd1: c = 2'd2;
      3'd2: c = 2'd0;
      3'd3: c = 2'd3;
      3'd4: c = 2'd2;
      3'd5: c = 2'd1;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

endpackage

### hw/rtl/uv_sphere_quad_vertex_gen_core.sv
// Top level of the UV-sphere quad vertex generator: register port, front end,
// quad queue and back end. Uses usq_pkg, usq_front, usq_queue and usq_back.
//
// Each accepted quad (longitude, latitude) yields six vertices, two triangles in the
// order p2,p3,p1,p4,p3,p2, with corner_slot 0..5 and last_vertex on slot 5. The result
// channel carries one vertex per cycle while out_ready is high; the front end works out
// the four phases of each quad with its divider and runs ahead of the back end through
// a two-entry queue. A vertex passes the ROM read, fold, radius-multiply and output
// registers after its corner is issued. After reset and after every slice_count write
// the block builds the slice reciprocal and holds in_ready low meanwhile; register
// writes are taken at any time. Registers: sphere_radius at 0x0, slice_count at 0x4.
module uv_sphere_quad_vertex_gen_core import usq_pkg::*; #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [LON_W-1:0]    in_longitude_index,
  input  logic [LAT_W-1:0]    in_latitude_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [COORD_W-1:0]  out_coord_x,
  output logic [COORD_W-1:0]  out_coord_y,
  output logic [COORD_W-1:0]  out_coord_z,
  output logic [SLOT_W-1:0]   out_corner_slot,
  output logic                out_in_range,
  output logic                out_last_vertex,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam logic [31:0] MAX_W = 32'(MAX_SLICES);

  logic [RADIUS_W-1:0] radius_r;
  logic [SLICE_W-1:0]  slices_r;
  logic                wr;
  reg_idx_t            widx;
  logic                rcp_start;

  assign pready    = 1'b1;
  assign wr        = psel && penable && pwrite;
  assign widx      = reg_idx_t'(paddr[2]);
  assign rcp_start = wr && (widx == REG_SLICES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
      slices_r <= SLICE_RESET;
    end else if (wr) begin
      case (widx)
        REG_RADIUS: radius_r <= (pwdata[13:0] > RADIUS_MAX) ? RADIUS_MAX : pwdata[13:0];
        REG_SLICES: begin
          if (pwdata[8:0] < SLICE_MIN) slices_r <= SLICE_MIN;
          else if (32'(pwdata[8:0]) > MAX_W) slices_r <= MAX_W[SLICE_W-1:0];
          else slices_r <= pwdata[8:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_RADIUS: prdata = {18'b0, radius_r};
      REG_SLICES: prdata = {23'b0, slices_r};
      default:    prdata = '0;
    endcase
  end

  logic  q_full, push, pop, head_valid;
  quad_t push_data, head;

  usq_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_longitude_index (in_longitude_index),
    .in_latitude_index  (in_latitude_index),
    .slices             (slices_r),
    .rcp_start          (rcp_start),
    .q_full             (q_full),
    .push               (push),
    .push_data          (push_data)
  );

  usq_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  usq_back #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .head_valid      (head_valid),
    .pop             (pop),
    .radius          (radius_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_coord_x     (out_coord_x),
    .out_coord_y     (out_coord_y),
    .out_coord_z     (out_coord_z),
    .out_corner_slot (out_corner_slot),
    .out_in_range    (out_in_range),
    .out_last_vertex (out_last_vertex)
  );

endmodule

### hw/rtl/usq_front.sv
// Front end: accepts quads, checks range and works out the four phases.
// Holds the reciprocal of slice_count, rebuilt after reset and each slice_count write. Uses usq_pkg.
module usq_front import usq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [LON_W-1:0]   in_longitude_index,
  input  logic [LAT_W-1:0]   in_latitude_index,
  input  logic [SLICE_W-1:0] slices,
  input  logic               rcp_start,
  input  logic               q_full,
  output logic               push,
  output quad_t              push_data
);

  localparam int unsigned NUM_W = SLICE_W + PHASE_W;
  localparam int unsigned QE_W  = 23;
  localparam logic [5:0]  RCP_LAST = 6'd32;

  logic               rcp_busy_r;
  logic [5:0]         rcp_cnt_r;
  logic [SLICE_W-1:0] rcp_rem_r;
  logic [RCP_W-1:0]   rcp_q_r;
  logic [SLICE_W:0]   rcp_rem2;
  logic               rcp_ge;
  logic [SLICE_W:0]   rcp_rem_nxt;

  always_comb begin
    rcp_rem2    = {rcp_rem_r, (rcp_cnt_r == 6'd0)};
    rcp_ge      = rcp_rem2 >= {1'b0, slices};
    rcp_rem_nxt = rcp_ge ? rcp_rem2 - {1'b0, slices} : rcp_rem2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcp_busy_r <= 1'b1;
      rcp_cnt_r  <= 6'd0;
      rcp_rem_r  <= '0;
    end else if (rcp_start) begin
      rcp_busy_r <= 1'b1;
      rcp_cnt_r  <= 6'd0;
      rcp_rem_r  <= '0;
    end else if (rcp_busy_r) begin
      rcp_rem_r <= rcp_rem_nxt[SLICE_W-1:0];
      rcp_q_r   <= {rcp_q_r[RCP_W-2:0], rcp_ge};
      rcp_cnt_r <= rcp_cnt_r + 6'd1;
      if (rcp_cnt_r == RCP_LAST) rcp_busy_r <= 1'b0;
    end
  end

  logic [LON_W-1:0] k_r;
  logic [LAT_W-1:0] i_r;
  logic             ok_r;
  logic [2:0]       cnt_r;
  logic             issuing;
  logic             adv;
  logic             accept;

  logic             a_v_r, b_v_r;
  logic [1:0]       a_idx_r, b_idx_r;
  logic             a_ok_r, b_ok_r;
  logic [NUM_W-1:0] a_num_r, b_num_r;
  logic [NUM_W+RCP_W-1:0] a_prod_r;
  logic [QE_W-1:0]  b_qe_r;
  logic [31:0]      b_dq_r;
  logic [PHASE_W-1:0] ph0_r, ph1_r, ph2_r;

  logic [SLICE_W-1:0] n_sel;
  logic [NUM_W-1:0]   num;
  logic [QE_W-1:0]    qe;
  logic [NUM_W-1:0]   rem;
  logic [QE_W-1:0]    q_fix;

  assign issuing  = !cnt_r[2];
  assign adv      = !(b_v_r && (b_idx_r == 2'd3) && q_full);
  assign in_ready = !rcp_busy_r && cnt_r[2];
  assign accept   = in_valid && in_ready;

  always_comb begin
    case (cnt_r[1:0])
      2'd0: n_sel = {1'b0, k_r};
      2'd1: n_sel = {1'b0, k_r} + 9'd1;
      2'd2: n_sel = {2'b0, i_r};
      2'd3: n_sel = {2'b0, i_r} + 9'd1;
      default: n_sel = '0;
    endcase
    num   = {n_sel, {PHASE_W{1'b0}}} + {{(PHASE_W+1){1'b0}}, slices[SLICE_W-1:1]};
    qe    = a_prod_r[NUM_W+RCP_W-1 -: QE_W];
    rem   = b_num_r - b_dq_r[NUM_W-1:0];
    q_fix = (rem >= {{PHASE_W{1'b0}}, slices}) ? b_qe_r + 23'd1 : b_qe_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd4;
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (accept) begin
        cnt_r <= 3'd0;
      end else if (issuing && adv) begin
        cnt_r <= cnt_r + 3'd1;
      end
      if (adv) begin
        a_v_r <= issuing;
        b_v_r <= a_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      k_r  <= in_longitude_index;
      i_r  <= in_latitude_index;
      ok_r <= ({1'b0, in_longitude_index} < slices) &&
              ({2'b0, in_latitude_index} < {1'b0, slices[SLICE_W-1:1]});
    end
    if (adv) begin
      a_idx_r  <= cnt_r[1:0];
      a_ok_r   <= ok_r;
      a_num_r  <= num;
      a_prod_r <= num * rcp_q_r;
      b_idx_r  <= a_idx_r;
      b_ok_r   <= a_ok_r;
      b_num_r  <= a_num_r;
      b_qe_r   <= qe;
      b_dq_r   <= 32'(qe * slices);
      if (b_v_r) begin
        case (b_idx_r)
          2'd0: ph0_r <= q_fix[PHASE_W-1:0];
          2'd1: ph1_r <= q_fix[PHASE_W-1:0];
          2'd2: ph2_r <= q_fix[PHASE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign push = b_v_r && (b_idx_r == 2'd3) && !q_full;
  always_comb begin
    push_data.ok   = b_ok_r;
    push_data.phi0 = ph0_r;
    push_data.phi1 = ph1_r;
    push_data.th0  = ph2_r;
    push_data.th1  = q_fix[PHASE_W-1:0];
  end

endmodule

### hw/rtl/usq_queue.sv
// Two-entry queue of classified quads between front end and back end.
// Uses usq_pkg for the entry type.
module usq_queue import usq_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  quad_t push_data,
  output logic  full,
  input  logic  pop,
  output quad_t head,
  output logic  head_valid
);

  quad_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full       = cnt_r == 2'd2;
  assign head_valid = cnt_r != 2'd0;
  assign head       = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

endmodule

### hw/rtl/usq_sine_rom.sv
// Quarter-wave sine ROM, unsigned Q0.15, two registered read ports.
// Contents are built at elaboration from a Taylor series. No dependencies.
module usq_sine_rom #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024,
  localparam int unsigned AW = $clog2(SINE_TABLE_DEPTH)
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AW-1:0] addr_a,
  input  logic [AW-1:0] addr_b,
  output logic [14:0]   data_a,
  output logic [14:0]   data_b
);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  typedef logic [14:0] rom_t [SINE_TABLE_DEPTH];

  function automatic rom_t build_rom();
    rom_t        t;
    logic [63:0] x, x2, s, v, q;
    for (int j = 0; j < SINE_TABLE_DEPTH; j++) begin
      x  = (64'(j) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
      x2 = (x * x) >> 30;
      s  = ONE_Q30;
      s  = ONE_Q30 - ((x2 * s) >> 30) / 156;
      s  = ONE_Q30 - ((x2 * s) >> 30) / 110;
      s  = ONE_Q30 - ((x2 * s) >> 30) / 72;
      s  = ONE_Q30 - ((x2 * s) >> 30) / 42;
      s  = ONE_Q30 - ((x2 * s) >> 30) / 20;
      s  = ONE_Q30 - ((x2 * s) >> 30) / 6;
      v  = (x * s) >> 30;
      q  = (v + 64'd16384) >> 15;
      if (q > 64'd32767) q = 64'd32767;
      t[j] = q[14:0];
    end
    return t;
  endfunction

  localparam rom_t ROM = build_rom();

  always_ff @(posedge clk) begin
    if (en) begin
      data_a <= ROM[addr_a];
      data_b <= ROM[addr_b];
    end
  end

endmodule

### hw/rtl/usq_back.sv
// Back end: walks the six corners of a queued quad, looks up sin/cos and
// forms the vertex coordinates. Uses usq_pkg and usq_sine_rom.
module usq_back import usq_pkg::*; #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024,
  localparam int unsigned AW = $clog2(SINE_TABLE_DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  quad_t               head,
  input  logic                head_valid,
  output logic                pop,
  input  logic [RADIUS_W-1:0] radius,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [COORD_W-1:0]  out_coord_x,
  output logic [COORD_W-1:0]  out_coord_y,
  output logic [COORD_W-1:0]  out_coord_z,
  output logic [SLOT_W-1:0]   out_corner_slot,
  output logic                out_in_range,
  output logic                out_last_vertex
);

  typedef struct packed {
    logic        full;
    logic        neg;
    logic [13:0] off;
  } lk_t;

  function automatic lk_t look(input logic [PHASE_W-1:0] p);
    lk_t         r;
    logic [14:0] off;
    off    = p[14] ? (15'h4000 - {1'b0, p[13:0]}) : {1'b0, p[13:0]};
    r.full = off[14];
    r.neg  = p[15];
    r.off  = off[13:0];
    return r;
  endfunction

  function automatic logic [AW-1:0] tab_addr(input logic [13:0] off);
    logic [31:0] prod;
    prod = 32'(off) * 32'(SINE_TABLE_DEPTH);
    return prod[14 +: AW];
  endfunction

  function automatic logic signed [15:0] fold(input logic [14:0] raw, input logic full,
                                               input logic neg);
    logic signed [15:0] v;
    v = full ? 16'sd32767 : $signed({1'b0, raw});
    return neg ? -v : v;
  endfunction

  logic              adv, issue;
  logic [SLOT_W-1:0] slot_r;
  logic [1:0]        corner;
  logic [PHASE_W-1:0] pa, ta;
  lk_t               ts, tc, ps, pc;
  logic [14:0]       ts_raw, tc_raw, ps_raw, pc_raw;

  assign adv   = !out_valid || out_ready;
  assign issue = head_valid && adv;
  assign pop   = issue && (slot_r == LAST_SLOT);

  always_comb begin
    corner = corner_of(slot_r);
    pa     = corner[0] ? head.phi1 : head.phi0;
    ta     = corner[1] ? head.th1 : head.th0;
    ts     = look(ta);
    tc     = look(ta + QUARTER_TURN);
    ps     = look(pa);
    pc     = look(pa + QUARTER_TURN);
  end

  usq_sine_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_rom_theta (
    .clk    (clk),
    .en     (adv),
    .addr_a (tab_addr(ts.off)),
    .addr_b (tab_addr(tc.off)),
    .data_a (ts_raw),
    .data_b (tc_raw)
  );

  usq_sine_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_rom_phi (
    .clk    (clk),
    .en     (adv),
    .addr_a (tab_addr(ps.off)),
    .addr_b (tab_addr(pc.off)),
    .data_a (ps_raw),
    .data_b (pc_raw)
  );

  logic v1_r, v2_r, v3_r;
  logic [SLOT_W-1:0] slot1_r, slot2_r, slot3_r;
  logic ok1_r, ok2_r, ok3_r;
  logic [1:0] ts_f_r, tc_f_r, ps_f_r, pc_f_r;
  logic signed [15:0] st2_r, ct2_r, sp2_r, cp2_r, sp3_r, cp3_r;
  logic [RADIUS_W-1:0] r2_r, r3_r;
  logic signed [30:0] rst3_r, rct3_r;
  logic signed [46:0] px, py;
  logic signed [30:0] rz;
  logic [COORD_W-1:0] x_nxt, y_nxt, z_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r    <= '0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) slot_r <= (slot_r == LAST_SLOT) ? '0 : slot_r + 3'd1;
      if (adv) begin
        v1_r      <= issue;
        v2_r      <= v1_r;
        v3_r      <= v2_r;
        out_valid <= v3_r;
      end
    end
  end

  always_comb begin
    px    = rst3_r * cp3_r;
    py    = rst3_r * sp3_r;
    rz    = rct3_r >>> 15;
    x_nxt = 16'(px >>> 30) - 16'(4096);
    y_nxt = 16'(py >>> 30);
    z_nxt = rz[15:0] + {2'b0, r3_r};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      slot1_r <= slot_r;
      ok1_r   <= head.ok;
      ts_f_r  <= {ts.full, ts.neg};
      tc_f_r  <= {tc.full, tc.neg};
      ps_f_r  <= {ps.full, ps.neg};
      pc_f_r  <= {pc.full, pc.neg};

      slot2_r <= slot1_r;
      ok2_r   <= ok1_r;
      st2_r   <= fold(ts_raw, ts_f_r[1], ts_f_r[0]);
      ct2_r   <= fold(tc_raw, tc_f_r[1], tc_f_r[0]);
      sp2_r   <= fold(ps_raw, ps_f_r[1], ps_f_r[0]);
      cp2_r   <= fold(pc_raw, pc_f_r[1], pc_f_r[0]);
      r2_r    <= radius;

      slot3_r <= slot2_r;
      ok3_r   <= ok2_r;
      rst3_r  <= $signed({1'b0, r2_r}) * st2_r;
      rct3_r  <= $signed({1'b0, r2_r}) * ct2_r;
      sp3_r   <= sp2_r;
      cp3_r   <= cp2_r;
      r3_r    <= r2_r;

      out_corner_slot <= slot3_r;
      out_in_range    <= ok3_r;
      out_last_vertex <= slot3_r == LAST_SLOT;
      out_coord_x     <= ok3_r ? x_nxt : '0;
      out_coord_y     <= ok3_r ? y_nxt : '0;
      out_coord_z     <= ok3_r ? z_nxt : '0;
    end
  end

endmodule

### hw/rtl/usq_checker.sv
// Port-level checks for the vertex generator, bound to the top level.
// Uses usq_pkg.
module usq_checker import usq_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COORD_W-1:0] out_coord_x,
  input logic [COORD_W-1:0] out_coord_y,
  input logic [COORD_W-1:0] out_coord_z,
  input logic [SLOT_W-1:0]  out_corner_slot,
  input logic               out_in_range,
  input logic               out_last_vertex
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_coord_x) &&
      $stable(out_coord_y) && $stable(out_coord_z) && $stable(out_corner_slot))
    else $error("stalled vertex changed");

  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_vertex == (out_corner_slot == LAST_SLOT)))
    else $error("last_vertex does not match slot");

  a_slot_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_vertex |=>
      !out_valid || (out_corner_slot == $past(out_corner_slot) + 3'd1))
    else $error("corner slot skipped");

  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_range |->
      out_coord_x == '0 && out_coord_y == '0 && out_coord_z == '0)
    else $error("out-of-range quad has coordinates");

endmodule

bind uv_sphere_quad_vertex_gen_core usq_checker u_usq_checker (.*);
